/* rtl/vcb_pkg.sv */
// ---------------------------------------------------------------------------
// vcb_pkg: shared types, constants and step functions
// Fixed-point constants, pipeline payload types and the per-stage steps of
// the square root and divider pipelines.
// ---------------------------------------------------------------------------
package vcb_pkg;

  localparam int FRAC_BITS = 16;

  // register indexes
  localparam logic [2:0] REG_DAMPING      = 3'd0;
  localparam logic [2:0] REG_DT_SQUARED   = 3'd1;
  localparam logic [2:0] REG_CENTRE_X     = 3'd2;
  localparam logic [2:0] REG_CENTRE_Y     = 3'd3;
  localparam logic [2:0] REG_BOUND_RADIUS = 3'd4;
  localparam logic [2:0] REG_PART_RADIUS  = 3'd5;

  // reset values
  localparam logic [16:0] DAMPING_RESET = 17'd65536;
  localparam logic [31:0] DT_SQ_RESET   = 32'd1099512;
  localparam logic [63:0] BR_RAW = 64'd300 << FRAC_BITS;
  localparam logic [63:0] PR_RAW = 64'd5 << FRAC_BITS;
  localparam logic [30:0] BR_RESET = (BR_RAW > 64'h7fff_ffff) ? 31'h7fff_ffff : BR_RAW[30:0];
  localparam logic [30:0] PR_RESET = (PR_RAW > 64'h7fff_ffff) ? 31'h7fff_ffff : PR_RAW[30:0];

  localparam int SQRT_STAGES = 33;
  localparam int DIV_STAGES  = 64;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  // pipeline control between modules
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // per-particle data carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               clamp;
    logic               neg_x;
    logic               neg_y;
  } side_t;

  // square root working state
  typedef struct packed {
    logic [65:0] rad;
    logic [33:0] rem;
    logic [32:0] root;
  } sq_t;

  // one divider lane: numerator/quotient shift word and remainder
  typedef struct packed {
    logic [63:0] nq;
    logic [32:0] rem;
  } dv_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fff_ffff;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // one radicand digit pair per step
  function automatic sq_t sqrt_step(input sq_t a);
    sq_t         r;
    logic [35:0] rs;
    logic [35:0] trial;
    rs    = {a.rem, a.rad[65:64]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = {a.rad[63:0], 2'b00};
    if (rs >= trial) begin
      rs     = rs - trial;
      r.rem  = rs[33:0];
      r.root = {a.root[31:0], 1'b1};
    end else begin
      r.rem  = rs[33:0];
      r.root = {a.root[31:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit per step, restoring
  function automatic dv_lane_t div_step(input dv_lane_t a, input logic [32:0] den);
    dv_lane_t    r;
    logic [33:0] rs;
    rs = {a.rem, a.nq[63]};
    if (rs >= {1'b0, den}) begin
      rs    = rs - {1'b0, den};
      r.rem = rs[32:0];
      r.nq  = {a.nq[62:0], 1'b1};
    end else begin
      r.rem = rs[32:0];
      r.nq  = {a.nq[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/vcb_if.sv */
// ---------------------------------------------------------------------------
// vcb_in_if / vcb_out_if: particle channels
// Valid/ready channels carrying one particle in and one result out.
// ---------------------------------------------------------------------------
interface vcb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  modport source (output valid, pos_x, pos_y, prev_x, prev_y, acc_x, acc_y, input ready);
  modport sink (input valid, pos_x, pos_y, prev_x, prev_y, acc_x, acc_y, output ready);
endinterface

interface vcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] old_x;
  logic signed [31:0] old_y;
  logic               clamped;
  modport source (output valid, new_x, new_y, old_x, old_y, clamped, input ready);
  modport sink (input valid, new_x, new_y, old_x, old_y, clamped, output ready);
endinterface

/* rtl/vcb_isqrt.sv */
// ---------------------------------------------------------------------------
// vcb_isqrt: pipelined integer square root
// floor(sqrt) of a 65-bit radicand, one digit pair per stage, 33 stages.
// ---------------------------------------------------------------------------
module vcb_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  vcb_pkg::pipe_ctl_t  ctl_in,
  input  logic [64:0]         rad,
  input  vcb_pkg::side_t      side_in,
  output logic                valid_out,
  output logic [32:0]         root,
  output vcb_pkg::side_t      side_out
);

  vcb_pkg::sq_t   st    [vcb_pkg::SQRT_STAGES];
  vcb_pkg::side_t sd    [vcb_pkg::SQRT_STAGES];
  logic           vld   [vcb_pkg::SQRT_STAGES];
  vcb_pkg::sq_t   st_in;

  assign st_in = '{rad: {1'b0, rad}, rem: '0, root: '0};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < vcb_pkg::SQRT_STAGES; s++) vld[s] <= 1'b0;
    end else if (ctl_in.en) begin
      vld[0] <= ctl_in.valid;
      for (int s = 1; s < vcb_pkg::SQRT_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      st[0] <= vcb_pkg::sqrt_step(st_in);
      sd[0] <= side_in;
      for (int s = 1; s < vcb_pkg::SQRT_STAGES; s++) begin
        st[s] <= vcb_pkg::sqrt_step(st[s-1]);
        sd[s] <= sd[s-1];
      end
    end
  end

  assign valid_out = vld[vcb_pkg::SQRT_STAGES-1];
  assign root      = st[vcb_pkg::SQRT_STAGES-1].root;
  assign side_out  = sd[vcb_pkg::SQRT_STAGES-1];

endmodule

/* rtl/vcb_div.sv */
// ---------------------------------------------------------------------------
// vcb_div: pipelined dual unsigned divider
// Two 64-bit numerators over a shared 33-bit divisor, one bit per stage.
// ---------------------------------------------------------------------------
module vcb_div (
  input  logic                clk,
  input  logic                rst,
  input  vcb_pkg::pipe_ctl_t  ctl_in,
  input  logic [63:0]         num_x,
  input  logic [63:0]         num_y,
  input  logic [32:0]         den,
  input  vcb_pkg::side_t      side_in,
  output logic                valid_out,
  output logic [63:0]         quot_x,
  output logic [63:0]         quot_y,
  output vcb_pkg::side_t      side_out
);

  vcb_pkg::dv_lane_t lx  [vcb_pkg::DIV_STAGES];
  vcb_pkg::dv_lane_t ly  [vcb_pkg::DIV_STAGES];
  logic [32:0]       dn  [vcb_pkg::DIV_STAGES];
  vcb_pkg::side_t    sd  [vcb_pkg::DIV_STAGES];
  logic              vld [vcb_pkg::DIV_STAGES];
  vcb_pkg::dv_lane_t lx_in;
  vcb_pkg::dv_lane_t ly_in;

  assign lx_in = '{nq: num_x, rem: '0};
  assign ly_in = '{nq: num_y, rem: '0};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < vcb_pkg::DIV_STAGES; s++) vld[s] <= 1'b0;
    end else if (ctl_in.en) begin
      vld[0] <= ctl_in.valid;
      for (int s = 1; s < vcb_pkg::DIV_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      lx[0] <= vcb_pkg::div_step(lx_in, den);
      ly[0] <= vcb_pkg::div_step(ly_in, den);
      dn[0] <= den;
      sd[0] <= side_in;
      for (int s = 1; s < vcb_pkg::DIV_STAGES; s++) begin
        lx[s] <= vcb_pkg::div_step(lx[s-1], dn[s-1]);
        ly[s] <= vcb_pkg::div_step(ly[s-1], dn[s-1]);
        dn[s] <= dn[s-1];
        sd[s] <= sd[s-1];
      end
    end
  end

  assign valid_out = vld[vcb_pkg::DIV_STAGES-1];
  assign quot_x    = lx[vcb_pkg::DIV_STAGES-1].nq;
  assign quot_y    = ly[vcb_pkg::DIV_STAGES-1].nq;
  assign side_out  = sd[vcb_pkg::DIV_STAGES-1];

endmodule

/* rtl/verlet_circular_boundary_step_core.sv */
// ---------------------------------------------------------------------------
// verlet_circular_boundary_step_core: damped Verlet step with circular wall
// Integrates one particle, then projects it back inside the boundary circle.
// ---------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     pos_x pos_y prev_x prev_y acc_x acc_y
//  out_ch    out  valid/ready     new_x new_y old_x old_y clamped
//  cfg       in   cfg_we          cfg_index, cfg_data
//
//  One particle per cycle unless the output stalls (6 integrate/square
//  stages, 33 square root stages, 2 product stages, 64 divider stages, output).
//  The whole pipeline advances together; a stalled output freezes every stage.
//  Reset (rst, synchronous) clears the valid bits and loads register defaults.
// ---------------------------------------------------------------------------
module verlet_circular_boundary_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vcb_in_if.sink      in_ch,
  vcb_out_if.source   out_ch
);

  // configuration registers
  logic        [16:0] damping;
  logic        [31:0] dt_squared;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic        [30:0] bound_radius;
  logic        [30:0] part_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping      <= vcb_pkg::DAMPING_RESET;
      dt_squared   <= vcb_pkg::DT_SQ_RESET;
      centre_x     <= '0;
      centre_y     <= '0;
      bound_radius <= vcb_pkg::BR_RESET;
      part_radius  <= vcb_pkg::PR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcb_pkg::REG_DAMPING:      damping      <= cfg_data[16:0];
        vcb_pkg::REG_DT_SQUARED:   dt_squared   <= cfg_data;
        vcb_pkg::REG_CENTRE_X:     centre_x     <= cfg_data;
        vcb_pkg::REG_CENTRE_Y:     centre_y     <= cfg_data;
        vcb_pkg::REG_BOUND_RADIUS: bound_radius <= cfg_data[30:0];
        vcb_pkg::REG_PART_RADIUS:  part_radius  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage registers
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v;
  logic signed [31:0] a_px, a_py, a_ax, a_ay;
  logic signed [32:0] a_dpx, a_dpy;
  logic signed [31:0] b_px, b_py;
  logic signed [50:0] b_vx, b_vy;
  logic signed [64:0] b_ax, b_ay;
  vcb_pkg::side_t     c_sd, d_sd, e_sd, f_sd, g_sd, h_sd;
  logic [31:0]        d_mx, d_my;
  logic [63:0]        e_sx, e_sy;
  logic [64:0]        f_rad;
  logic signed [64:0] g_px, g_py;
  logic [32:0]        g_den, h_den;
  logic [63:0]        h_nx, h_ny;

  logic               sq_v;
  logic [32:0]        sq_root;
  vcb_pkg::side_t     sq_sd;
  logic               dv_v;
  logic [63:0]        dv_qx, dv_qy;
  vcb_pkg::side_t     dv_sd;

  // combinational helpers
  logic signed [65:0] c_sum_x, c_sum_y;
  logic signed [32:0] d_dx, d_dy;
  logic signed [31:0] k_fac;
  logic [33:0]        g_reach;
  logic signed [65:0] o_qx, o_qy;
  vcb_pkg::side_t     c_sd_next, d_sd_next, g_sd_next, h_sd_next;

  assign c_sum_x = 66'(b_px) + 66'(b_vx >>> 16) + 66'(b_ax >>> 32);
  assign c_sum_y = 66'(b_py) + 66'(b_vy >>> 16) + 66'(b_ay >>> 32);
  assign d_dx    = 33'(c_sd.new_x) - 33'(centre_x);
  assign d_dy    = 33'(c_sd.new_y) - 33'(centre_y);
  assign k_fac   = $signed({1'b0, bound_radius}) - $signed({1'b0, part_radius});
  assign g_reach = {1'b0, sq_root} + {3'b000, part_radius};
  assign o_qx    = dv_sd.neg_x ? -$signed({2'b00, dv_qx}) : $signed({2'b00, dv_qx});
  assign o_qy    = dv_sd.neg_y ? -$signed({2'b00, dv_qy}) : $signed({2'b00, dv_qy});

  // side data with the fields each stage fills in
  always_comb begin
    c_sd_next       = '0;
    c_sd_next.old_x = b_px;
    c_sd_next.old_y = b_py;
    c_sd_next.new_x = vcb_pkg::sat32(c_sum_x);
    c_sd_next.new_y = vcb_pkg::sat32(c_sum_y);
    d_sd_next       = c_sd;
    d_sd_next.dx    = d_dx;
    d_sd_next.dy    = d_dy;
    g_sd_next       = sq_sd;
    g_sd_next.clamp = (sq_root != '0) && (g_reach > {3'b000, bound_radius});
    h_sd_next       = g_sd;
    h_sd_next.neg_x = g_px[64];
    h_sd_next.neg_y = g_py[64];
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      {a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v} <= '0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      a_v <= in_ch.valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= sq_v;
      h_v <= g_v;
      out_ch.valid <= dv_v;
    end
  end

  // integration, distance squares, radial products, divider operands, result
  always_ff @(posedge clk) begin
    if (en) begin
      // capture and velocity difference
      a_px  <= in_ch.pos_x;
      a_py  <= in_ch.pos_y;
      a_ax  <= in_ch.acc_x;
      a_ay  <= in_ch.acc_y;
      a_dpx <= 33'(in_ch.pos_x) - 33'(in_ch.prev_x);
      a_dpy <= 33'(in_ch.pos_y) - 33'(in_ch.prev_y);
      // damping and acceleration products
      b_px <= a_px;
      b_py <= a_py;
      b_vx <= 51'(a_dpx * $signed({1'b0, damping}));
      b_vy <= 51'(a_dpy * $signed({1'b0, damping}));
      b_ax <= 65'(a_ax * $signed({1'b0, dt_squared}));
      b_ay <= 65'(a_ay * $signed({1'b0, dt_squared}));
      // saturated integration
      c_sd <= c_sd_next;
      // offset from centre
      d_sd <= d_sd_next;
      d_mx <= d_dx[32] ? 32'(-d_dx) : d_dx[31:0];
      d_my <= d_dy[32] ? 32'(-d_dy) : d_dy[31:0];
      // squares
      e_sd <= d_sd;
      e_sx <= d_mx * d_mx;
      e_sy <= d_my * d_my;
      // radicand
      f_sd  <= e_sd;
      f_rad <= {1'b0, e_sx} + {1'b0, e_sy};
      // clamp test and radial products
      g_sd  <= g_sd_next;
      g_px  <= 65'(sq_sd.dx * k_fac);
      g_py  <= 65'(sq_sd.dy * k_fac);
      g_den <= sq_root;
      // magnitudes and signs for the divider
      h_sd  <= h_sd_next;
      h_nx  <= g_px[64] ? 64'(-g_px) : g_px[63:0];
      h_ny  <= g_py[64] ? 64'(-g_py) : g_py[63:0];
      h_den <= g_den;
      // result register
      out_ch.old_x   <= dv_sd.old_x;
      out_ch.old_y   <= dv_sd.old_y;
      out_ch.clamped <= dv_sd.clamp;
      if (dv_sd.clamp) begin
        out_ch.new_x <= vcb_pkg::sat32(66'(centre_x) + o_qx);
        out_ch.new_y <= vcb_pkg::sat32(66'(centre_y) + o_qy);
      end else begin
        out_ch.new_x <= dv_sd.new_x;
        out_ch.new_y <= dv_sd.new_y;
      end
    end
  end

  vcb_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    ('{en: en, valid: f_v}),
    .rad       (f_rad),
    .side_in   (f_sd),
    .valid_out (sq_v),
    .root      (sq_root),
    .side_out  (sq_sd)
  );

  vcb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    ('{en: en, valid: h_v}),
    .num_x     (h_nx),
    .num_y     (h_ny),
    .den       (h_den),
    .side_in   (h_sd),
    .valid_out (dv_v),
    .quot_x    (dv_qx),
    .quot_y    (dv_qy),
    .side_out  (dv_sd)
  );

  // checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");
  a_stall_sqrt: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sq_v) && $stable(sq_root))
    else $error("square root pipeline moved during stall");
  a_stall_div: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_v) && $stable(dv_qx) && $stable(dv_qy))
    else $error("divider pipeline moved during stall");
  a_clamp_radius: assert property (@(posedge clk) disable iff (rst)
    en && g_v && g_sd.clamp |-> g_den != '0)
    else $error("clamp raised at zero distance");

endmodule

/* sim/tb_verlet_circular_boundary_step_core.sv */
// ---------------------------------------------------------------------------
// tb_verlet_circular_boundary_step_core: self-checking bench for the Verlet core
// Drives particles through the input channel under random idling on both
// sides, predicts each damped Verlet step with its circular wall projection in
// wide integer arithmetic, and checks every output transaction in order.
// Several register settings are visited, written only while the core is idle.
// ---------------------------------------------------------------------------
module tb_verlet_circular_boundary_step_core;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PIPE_DRAIN = 120;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, prev_x, prev_y, acc_x, acc_y;
  } particle_t;

  typedef struct {
    logic signed [31:0] new_x, new_y, old_x, old_y;
    logic               clamped;
  } step_t;

  // scoreboard: register copy, step predictor and queue of expected steps
  class step_scoreboard;
    logic [16:0]        damping;
    logic [31:0]        dt_sq;
    logic signed [31:0] cx, cy;
    logic [30:0]        bound_r, part_r;
    step_t              pending_steps[$];

    function new();
      damping = vcb_pkg::DAMPING_RESET;
      dt_sq   = vcb_pkg::DT_SQ_RESET;
      cx      = '0;
      cy      = '0;
      bound_r = vcb_pkg::BR_RESET;
      part_r  = vcb_pkg::PR_RESET;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        vcb_pkg::REG_DAMPING:      damping = d[16:0];
        vcb_pkg::REG_DT_SQUARED:   dt_sq   = d;
        vcb_pkg::REG_CENTRE_X:     cx      = d;
        vcb_pkg::REG_CENTRE_Y:     cy      = d;
        vcb_pkg::REG_BOUND_RADIUS: bound_r = d[30:0];
        vcb_pkg::REG_PART_RADIUS:  part_r  = d[30:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] clip32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 128'sd2147483647;
      if (v < -128'sd2147483648) return -128'sd2147483648;
      return v;
    endfunction

    // pos + floor((pos-prev)*damping/2^16) + floor(acc*dt^2/2^32), saturated
    function logic signed [127:0] integrate(logic signed [31:0] p, logic signed [31:0] q,
                                            logic signed [31:0] a);
      logic signed [127:0] pw, qw, aw, dw, tw;
      pw = p;
      qw = q;
      aw = a;
      dw = damping;
      tw = dt_sq;
      return clip32(pw + (((pw - qw) * dw) >>> 16) + ((aw * tw) >>> 32));
    endfunction

    function step_t predict(particle_t p);
      step_t               r;
      logic signed [127:0] nx, ny, dx, dy, cxw, cyw, k, radial;
      logic [127:0]        sq, rem, root, trial;
      nx  = integrate(p.pos_x, p.prev_x, p.acc_x);
      ny  = integrate(p.pos_y, p.prev_y, p.acc_y);
      cxw = cx;
      cyw = cy;
      dx  = nx - cxw;
      dy  = ny - cyw;
      sq  = dx * dx + dy * dy;
      rem  = '0;
      root = '0;
      // bitwise integer square root, two radicand bits per step
      for (int i = 32; i >= 0; i--) begin
        rem   = (rem << 2) | ((sq >> (2 * i)) & 128'd3);
        trial = (root << 2) | 128'd1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 128'd1;
        end else begin
          root = root << 1;
        end
      end
      radial = root;
      r.clamped = 1'b0;
      if (radial != 0 && radial + part_r > bound_r) begin
        k  = $signed({97'd0, bound_r}) - $signed({97'd0, part_r});
        nx = clip32(cxw + (dx * k) / radial);
        ny = clip32(cyw + (dy * k) / radial);
        r.clamped = 1'b1;
      end
      r.new_x = nx[31:0];
      r.new_y = ny[31:0];
      r.old_x = p.pos_x;
      r.old_y = p.pos_y;
      return r;
    endfunction

    function void note(particle_t p);
      pending_steps = {pending_steps, predict(p)};
    endfunction

    // returns 1 when the result matches the oldest expectation
    function bit check(step_t got, output string msg);
      step_t e;
      msg = "";
      if (pending_steps.size() == 0) begin
        msg = "result with no expectation waiting";
        return 0;
      end
      e = pending_steps.pop_front();
      if (got.new_x !== e.new_x) msg = {msg, $sformatf(" new_x %0d/%0d", got.new_x, e.new_x)};
      if (got.new_y !== e.new_y) msg = {msg, $sformatf(" new_y %0d/%0d", got.new_y, e.new_y)};
      if (got.old_x !== e.old_x) msg = {msg, $sformatf(" old_x %0d/%0d", got.old_x, e.old_x)};
      if (got.old_y !== e.old_y) msg = {msg, $sformatf(" old_y %0d/%0d", got.old_y, e.old_y)};
      if (got.clamped !== e.clamped)
        msg = {msg, $sformatf(" clamped %0b/%0b", got.clamped, e.clamped)};
      return msg == "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  vcb_in_if  in_ch ();
  vcb_out_if out_ch ();

  verlet_circular_boundary_step_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #10 clk = ~clk;

  step_scoreboard sb = new();
  particle_t      particle_queue[$];
  particle_t      cur_particle;
  bit             holding;
  int             src_idle, snk_idle;
  int             error_count;

  task automatic report(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    error_count++;
  endtask

  // append a particle to the stimulus queue
  task automatic enqueue(particle_t p);
    particle_queue = {particle_queue, p};
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.prev_x = '0;
    in_ch.prev_y = '0;
    in_ch.acc_x  = '0;
    in_ch.acc_y  = '0;
    out_ch.ready = 1'b0;
    holding      = 1'b0;
    error_count  = 0;
  end

  // particle source: note each transaction, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note(cur_particle);
        holding = 1'b0;
      end
      if (!holding) begin
        if (particle_queue.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur_particle = particle_queue.pop_front();
          in_ch.pos_x  <= cur_particle.pos_x;
          in_ch.pos_y  <= cur_particle.pos_y;
          in_ch.prev_x <= cur_particle.prev_x;
          in_ch.prev_y <= cur_particle.prev_y;
          in_ch.acc_x  <= cur_particle.acc_x;
          in_ch.acc_y  <= cur_particle.acc_y;
          in_ch.valid  <= 1'b1;
          holding = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk) begin
    step_t got;
    string msg;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.new_x   = out_ch.new_x;
        got.new_y   = out_ch.new_y;
        got.old_x   = out_ch.old_x;
        got.old_y   = out_ch.old_y;
        got.clamped = out_ch.clamped;
        if (!sb.check(got, msg)) report(msg);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the core to empty, then let the pipeline settle
  task automatic drain();
    while (particle_queue.size() > 0 || holding || sb.pending_steps.size() > 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic particle_t make_particle(logic [31:0] px, logic [31:0] py,
                                              logic [31:0] qx, logic [31:0] qy,
                                              logic [31:0] ax, logic [31:0] ay);
    particle_t p;
    p.pos_x  = px;
    p.pos_y  = py;
    p.prev_x = qx;
    p.prev_y = qy;
    p.acc_x  = ax;
    p.acc_y  = ay;
    return p;
  endfunction

  // mostly particles near the wall around the centre, some raw noise
  task automatic queue_random(int n, int span);
    logic [31:0] px, py;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: enqueue(make_particle($urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
        default: begin
          px = sb.cx + $signed($urandom_range(2 * span)) - span;
          py = sb.cy + $signed($urandom_range(2 * span)) - span;
          enqueue(make_particle(px, py,
            px + $signed($urandom_range(2 << 16)) - (1 << 16),
            py + $signed($urandom_range(2 << 16)) - (1 << 16),
            $signed($urandom_range(1 << 24)) - (1 << 23),
            $signed($urandom_range(1 << 24)) - (1 << 23)));
        end
      endcase
    end
  endtask

  initial begin
    int span;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle = 32;
    snk_idle = 50;

    // directed: extremes, zero distance, wall hits, saturation
    enqueue(make_particle(0, 0, 0, 0, 0, 0));
    enqueue(make_particle(1, 0, 1, 0, 0, 0));
    enqueue(make_particle(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                          32'h80000000, 32'h7fffffff, 32'h7fffffff));
    enqueue(make_particle(32'h80000000, 32'h80000000, 32'h7fffffff,
                          32'h7fffffff, 32'h80000000, 32'h80000000));
    enqueue(make_particle(32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 32'hffffffff, 32'hffffffff));
    enqueue(make_particle(295 << 16, 0, 295 << 16, 0, 0, 0));
    enqueue(make_particle(296 << 16, 0, 295 << 16, 0, 0, 0));
    enqueue(make_particle(0, -(400 << 16), 0, -(390 << 16), 0, 0));
    enqueue(make_particle(250 << 16, 250 << 16, 240 << 16, 240 << 16,
                          1 << 20, 1 << 20));
    enqueue(make_particle(-(100 << 16), 50 << 16, -(100 << 16), 50 << 16,
                          32'h80000000, 32'h7fffffff));
    enqueue(make_particle(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa,
                          32'h55555555, 32'h55555555, 32'haaaaaaaa));
    drain();

    // setting sweep: each setting followed by random particles
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        src_idle = 50;
        snk_idle = 32;
      end else if (ph == 8) begin
        src_idle = 0;
        snk_idle = 0;
      end
      case (ph)
        0: begin
          write_reg(vcb_pkg::REG_DAMPING, 0);
          write_reg(vcb_pkg::REG_DT_SQUARED, 0);
        end
        1: begin
          write_reg(vcb_pkg::REG_DAMPING, 32'h1ffff);
          write_reg(vcb_pkg::REG_DT_SQUARED, 32'hffffffff);
        end
        2: begin
          write_reg(vcb_pkg::REG_CENTRE_X, 32'h7fffffff);
          write_reg(vcb_pkg::REG_CENTRE_Y, 32'h80000000);
          write_reg(vcb_pkg::REG_BOUND_RADIUS, 31'h7fffffff);
        end
        3: begin
          write_reg(vcb_pkg::REG_CENTRE_X, 32'h80000000);
          write_reg(vcb_pkg::REG_CENTRE_Y, 32'h7fffffff);
          write_reg(vcb_pkg::REG_BOUND_RADIUS, 0);
          write_reg(vcb_pkg::REG_PART_RADIUS, 0);
        end
        4: begin
          // particle larger than the boundary
          write_reg(vcb_pkg::REG_CENTRE_X, 0);
          write_reg(vcb_pkg::REG_CENTRE_Y, 0);
          write_reg(vcb_pkg::REG_BOUND_RADIUS, 10 << 16);
          write_reg(vcb_pkg::REG_PART_RADIUS, 40 << 16);
          write_reg(vcb_pkg::REG_DAMPING, 65536);
        end
        5: begin
          write_reg(vcb_pkg::REG_PART_RADIUS, 31'h7fffffff);
          write_reg(vcb_pkg::REG_BOUND_RADIUS, 31'h7fffffff);
        end
        6: begin
          write_reg(REG_UNUSED, 32'hffffffff);
          write_reg(vcb_pkg::REG_BOUND_RADIUS, vcb_pkg::BR_RESET);
          write_reg(vcb_pkg::REG_PART_RADIUS, vcb_pkg::PR_RESET);
          write_reg(vcb_pkg::REG_DT_SQUARED, vcb_pkg::DT_SQ_RESET);
        end
        default: begin
          write_reg(vcb_pkg::REG_DAMPING, $urandom_range(32'h1ffff));
          write_reg(vcb_pkg::REG_DT_SQUARED, $urandom);
          write_reg(vcb_pkg::REG_CENTRE_X, $signed($urandom_range(1 << 26)) - (1 << 25));
          write_reg(vcb_pkg::REG_CENTRE_Y, $signed($urandom_range(1 << 26)) - (1 << 25));
          write_reg(vcb_pkg::REG_BOUND_RADIUS, $urandom_range(1 << 26));
          write_reg(vcb_pkg::REG_PART_RADIUS, $urandom_range(1 << 22));
        end
      endcase
      span = (sb.bound_r > (1 << 28)) ? (1 << 28) : sb.bound_r + (sb.bound_r >> 2) + 4096;
      queue_random(100, span);
      drain();
    end

    if (error_count == 0) begin
      $display("tb_verlet_circular_boundary_step_core: done, clean");
    end else begin
      $display("tb_verlet_circular_boundary_step_core: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("tb_verlet_circular_boundary_step_core: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/vcb_pkg.sv
rtl/vcb_if.sv
rtl/vcb_isqrt.sv
rtl/vcb_div.sv
rtl/verlet_circular_boundary_step_core.sv
sim/tb_verlet_circular_boundary_step_core.sv
